FILE: rtl/wuf_pkg.sv
// wuf_pkg: shared constants, request/result structs and table port structs
// for the weighted union-find core. No dependencies.
`default_nettype none

package wuf_pkg;

  localparam int MAX_SITES = 1024;
  localparam int SITE_W    = $clog2(MAX_SITES);
  localparam int SIZE_W    = SITE_W + 1;
  localparam int CFG_W     = 11;

  localparam logic [SITE_W-1:0] SITE_LAST  = SITE_W'(MAX_SITES - 1);
  localparam logic [SIZE_W-1:0] SIZE_ONE   = SIZE_W'(1);
  localparam logic [CFG_W-1:0]  CFG_RESET  = CFG_W'(1024);
  localparam logic [CFG_W-1:0]  CFG_MAX    = CFG_W'(MAX_SITES);

  // request kinds; the unused code behaves as a query
  localparam logic [1:0] KIND_QUERY  = 2'd0;
  localparam logic [1:0] KIND_MERGE  = 2'd1;
  localparam logic [1:0] KIND_REINIT = 2'd2;

  typedef struct packed {
    logic [1:0]        kind;
    logic [SITE_W-1:0] site_p;
    logic [SITE_W-1:0] site_q;
  } wuf_req_t;

  typedef struct packed {
    logic              same_set;
    logic [SITE_W-1:0] root_p;
    logic [SITE_W-1:0] root_q;
    logic              out_of_range;
  } wuf_res_t;

  typedef struct packed {
    logic              we;
    logic [SITE_W-1:0] waddr;
    logic [SITE_W-1:0] wdata;
    logic [SITE_W-1:0] raddr;
  } pt_port_t;

  typedef struct packed {
    logic              we;
    logic [SITE_W-1:0] waddr;
    logic [SIZE_W-1:0] wdata;
    logic [SITE_W-1:0] raddr;
  } sz_port_t;

endpackage

`default_nettype wire

FILE: rtl/wuf_if.sv
// Channel interfaces for the weighted union-find core: request, result
// and configuration words. Depends on wuf_pkg.
`default_nettype none

interface wuf_in_if import wuf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic [SITE_W-1:0] site_p;
  logic [SITE_W-1:0] site_q;

  modport source (output valid, kind, site_p, site_q, input ready);
  modport sink   (input valid, kind, site_p, site_q, output ready);
endinterface

interface wuf_out_if import wuf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              same_set;
  logic [SITE_W-1:0] root_p;
  logic [SITE_W-1:0] root_q;
  logic              out_of_range;

  modport source (output valid, same_set, root_p, root_q, out_of_range, input ready);
  modport sink   (input valid, same_set, root_p, root_q, out_of_range, output ready);
endinterface

interface wuf_cfg_if import wuf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] sites_in_use;

  modport source (output valid, sites_in_use, input ready);
  modport sink   (input valid, sites_in_use, output ready);
endinterface

`default_nettype wire

FILE: rtl/wuf_ram.sv
// wuf_ram: generic single-write, single-read RAM with registered read data.
// No package dependency.
`default_nettype none

module wuf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/wuf_ctrl.sv
// wuf_ctrl: sequencer for root walks, size compare/add and table writes,
// plus the table clearing sweep. Depends on wuf_pkg.
`default_nettype none

module wuf_ctrl import wuf_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire wuf_req_t          in_req,
  output logic                   in_ready,
  input  wire logic [CFG_W-1:0]  limit,
  output pt_port_t               pt_port,
  input  wire logic [SITE_W-1:0] pt_rdata,
  output sz_port_t               sz_port,
  input  wire logic [SIZE_W-1:0] sz_rdata,
  output logic                   res_valid,
  output wuf_res_t               res,
  input  wire logic              res_take
);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_WALK_P, ST_WALK_Q, ST_SIZE_P, ST_SIZE_Q, ST_RESULT
  } state_t;

  state_t            state_r, state_nxt;
  logic [SITE_W-1:0] clr_r, clr_nxt;
  logic              reply_r, reply_nxt;
  logic [1:0]        kind_r, kind_nxt;
  logic [SITE_W-1:0] q_r, q_nxt;
  logic [SITE_W-1:0] site_r, site_nxt;
  logic [SIZE_W-1:0] szp_r, szp_nxt;
  wuf_res_t          res_r, res_nxt;
  logic [SIZE_W-1:0] size_sum;
  logic              p_smaller;

  // arithmetic for the link step: size compare and sum
  assign size_sum  = szp_r + sz_rdata;
  assign p_smaller = szp_r < sz_rdata;

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    reply_nxt = reply_r;
    kind_nxt  = kind_r;
    q_nxt     = q_r;
    site_nxt  = site_r;
    szp_nxt   = szp_r;
    res_nxt   = res_r;
    pt_port   = '0;
    sz_port   = '0;
    sz_port.raddr = res_r.root_p;
    case (state_r)
      ST_CLEAR: begin
        pt_port.we    = 1'b1;
        pt_port.waddr = clr_r;
        pt_port.wdata = clr_r;
        sz_port.we    = 1'b1;
        sz_port.waddr = clr_r;
        sz_port.wdata = SIZE_ONE;
        clr_nxt       = clr_r + SITE_W'(1);
        if (clr_r == SITE_LAST) begin
          state_nxt = reply_r ? ST_RESULT : ST_IDLE;
          reply_nxt = 1'b0;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          kind_nxt = in_req.kind;
          q_nxt    = in_req.site_q;
          res_nxt  = '0;
          if (in_req.kind == KIND_REINIT) begin
            clr_nxt   = '0;
            reply_nxt = 1'b1;
            state_nxt = ST_CLEAR;
          end else if ({1'b0, in_req.site_p} >= limit || {1'b0, in_req.site_q} >= limit) begin
            res_nxt.out_of_range = 1'b1;
            state_nxt = ST_RESULT;
          end else begin
            site_nxt  = in_req.site_p;
            state_nxt = ST_WALK_P;
          end
        end
      end
      ST_WALK_P: begin
        if (pt_rdata == site_r) begin
          res_nxt.root_p = site_r;
          site_nxt  = q_r;
          state_nxt = ST_WALK_Q;
        end else begin
          site_nxt = pt_rdata;
        end
      end
      ST_WALK_Q: begin
        if (pt_rdata == site_r) begin
          res_nxt.root_q   = site_r;
          res_nxt.same_set = (site_r == res_r.root_p);
          if (kind_r == KIND_MERGE && site_r != res_r.root_p) begin
            state_nxt = ST_SIZE_P;   // size[root_p] read issued here
          end else begin
            state_nxt = ST_RESULT;
          end
        end else begin
          site_nxt = pt_rdata;
        end
      end
      ST_SIZE_P: begin
        szp_nxt       = sz_rdata;
        sz_port.raddr = res_r.root_q;
        state_nxt     = ST_SIZE_Q;
      end
      ST_SIZE_Q: begin
        pt_port.we    = 1'b1;
        sz_port.we    = 1'b1;
        sz_port.wdata = size_sum;
        if (p_smaller) begin
          pt_port.waddr = res_r.root_p;
          pt_port.wdata = res_r.root_q;
          sz_port.waddr = res_r.root_q;
        end else begin
          pt_port.waddr = res_r.root_q;
          pt_port.wdata = res_r.root_p;
          sz_port.waddr = res_r.root_p;
        end
        state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    pt_port.raddr = site_nxt;
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign res_valid = (state_r == ST_RESULT);
  assign res       = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      reply_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      reply_r <= reply_nxt;
    end
    kind_r <= kind_nxt;
    q_r    <= q_nxt;
    site_r <= site_nxt;
    szp_r  <= szp_nxt;
    res_r  <= res_nxt;
  end

endmodule

`default_nettype wire

FILE: rtl/weighted_union_find_core.sv
// weighted_union_find_core: top level of the weighted quick-union engine.
// Depends on wuf_pkg, wuf_if, wuf_ram and wuf_ctrl.
//
// Disjoint-set engine over 1024 sites. Each request word carries a kind
// (query, merge, reinitialise) and two sites. Exactly one result word comes
// back per request. A small sequencer works one request at a time around two
// single-port-read RAMs (parent and subtree size). An out-of-range request
// goes straight to the result. A query, or a merge of sites already joined,
// walks p to its root and then q to its root; a merge of separate sets then
// reads both root sizes and writes the new parent link and size sum. A walk
// reads the parent RAM once per level and once more at the root. Weighting
// keeps each tree depth at or below 10. Reinitialise runs a clearing sweep,
// one entry of both tables per cycle, then gives the result. Reset runs the
// same sweep, and no request is accepted until it is done. The core is ready
// again in the cycle after the result is loaded into the output register, so
// it takes no new request before the last one is through. The load waits
// while the output register holds a word that has not been taken downstream.
// Configuration writes are accepted at any time (cfg ready is tied high) but
// must only be issued while the core is idle. The output register lets the
// next request enter while a finished result still waits downstream.
`default_nettype none

module weighted_union_find_core import wuf_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  wuf_in_if.sink    in_chan,
  wuf_out_if.source out_chan,
  wuf_cfg_if.sink   cfg_chan
);

  logic [CFG_W-1:0]  cfg_r;
  logic [CFG_W-1:0]  limit;
  wuf_req_t          req;
  pt_port_t          pt_port;
  sz_port_t          sz_port;
  logic [SITE_W-1:0] pt_rdata;
  logic [SIZE_W-1:0] sz_rdata;
  logic              res_valid;
  wuf_res_t          res;
  logic              res_take;
  logic              out_valid_r;
  wuf_res_t          out_r;

  // site count register; values above the table depth clamp to it
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_chan.valid) begin
      cfg_r <= cfg_chan.sites_in_use;
    end
  end

  assign limit = (cfg_r > CFG_MAX) ? CFG_MAX : cfg_r;

  assign req.kind   = in_chan.kind;
  assign req.site_p = in_chan.site_p;
  assign req.site_q = in_chan.site_q;

  // parent table
  wuf_ram #(.WIDTH(SITE_W), .DEPTH(MAX_SITES)) u_parent (
    .clk   (clk),
    .we    (pt_port.we),
    .waddr (pt_port.waddr),
    .wdata (pt_port.wdata),
    .raddr (pt_port.raddr),
    .rdata (pt_rdata)
  );

  // subtree size table
  wuf_ram #(.WIDTH(SIZE_W), .DEPTH(MAX_SITES)) u_size (
    .clk   (clk),
    .we    (sz_port.we),
    .waddr (sz_port.waddr),
    .wdata (sz_port.wdata),
    .raddr (sz_port.raddr),
    .rdata (sz_rdata)
  );

  wuf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_req    (req),
    .in_ready  (in_chan.ready),
    .limit     (limit),
    .pt_port   (pt_port),
    .pt_rdata  (pt_rdata),
    .sz_port   (sz_port),
    .sz_rdata  (sz_rdata),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  // output register: takes a new result when empty or being drained
  assign res_take = !out_valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
    if (res_valid && res_take) begin
      out_r <= res;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.same_set     = out_r.same_set;
  assign out_chan.root_p       = out_r.root_p;
  assign out_chan.root_q       = out_r.root_q;
  assign out_chan.out_of_range = out_r.out_of_range;

endmodule

`default_nettype wire

FILE: dv/tb_weighted_union_find_core.sv
// Self-checking testbench for weighted_union_find_core: drives request and
// configuration words, predicts every result word and checks them in order.
// Depends on wuf_pkg, the channel interfaces in wuf_if and the core itself.
`default_nettype none

module tb_weighted_union_find_core import wuf_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // unused request code; the core treats it as a query
  localparam logic [1:0] KIND_SPARE = 2'd3;

  // clearing sweep after reset or reinit is one table entry per cycle
  localparam int SWEEP_SETTLE = MAX_SITES + 64;
  // longest non-reinit request is a merge of two depth-10 sites plus output register
  localparam int TAIL_CYCLES  = 64;
  // about 1000 words, ~30 sweeps, a dozen config pauses
  localparam int CYCLE_LIMIT  = 500_000;
  localparam int REPORT_MAX   = 10;

  logic clk;
  logic rst_n;

  wuf_in_if  in_if  ();
  wuf_out_if out_if ();
  wuf_cfg_if cfg_if ();

  weighted_union_find_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  // ---------------------------------------------------------------------------
  // Shadow copy of the disjoint-set state and the site-count register.
  // ---------------------------------------------------------------------------
  logic [SITE_W-1:0] shadow_parent [MAX_SITES];
  logic [SIZE_W-1:0] shadow_size   [MAX_SITES];
  logic [CFG_W-1:0]  shadow_site_count;

  wuf_res_t predicted_answers [$];   // one per accepted request word, in order
  int       mismatch_count;
  bit       steady_flow;             // set for the last part: no random valid gaps or ready drops

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop; nothing legal takes anywhere near this long
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic void clear_shadow_tables();
    for (int i = 0; i < MAX_SITES; i++) begin
      shadow_parent[i] = SITE_W'(i);
      shadow_size[i]   = SIZE_ONE;
    end
  endfunction

  // walk parent links up to the root; the step count is bounded by the table depth
  function automatic logic [SITE_W-1:0] walk_to_root(input logic [SITE_W-1:0] site);
    int steps;
    steps = 0;
    while (steps < MAX_SITES && shadow_parent[site] != site) begin
      site = shadow_parent[site];
      steps++;
    end
    return site;
  endfunction

  // answer one request and apply its merge to the shadow tables
  function automatic wuf_res_t union_find_step(input wuf_req_t req);
    wuf_res_t          ans;
    int unsigned       live_sites;
    logic [SITE_W-1:0] rp;
    logic [SITE_W-1:0] rq;
    ans = '0;
    if (req.kind == KIND_REINIT) begin
      clear_shadow_tables();
      return ans;
    end
    // register values above the table depth clamp to the table depth
    live_sites = (shadow_site_count > CFG_MAX) ? MAX_SITES : shadow_site_count;
    if (req.site_p >= live_sites || req.site_q >= live_sites) begin
      ans.out_of_range = 1'b1;
      return ans;
    end
    rp = walk_to_root(req.site_p);
    rq = walk_to_root(req.site_q);
    ans.same_set = (rp == rq);
    ans.root_p   = rp;
    ans.root_q   = rq;
    // smaller tree goes under the larger; on a tie q's root goes under p's
    if (req.kind == KIND_MERGE && rp != rq) begin
      if (shadow_size[rp] < shadow_size[rq]) begin
        shadow_parent[rp] = rq;
        shadow_size[rq]   = shadow_size[rq] + shadow_size[rp];
      end else begin
        shadow_parent[rq] = rp;
        shadow_size[rp]   = shadow_size[rp] + shadow_size[rq];
      end
    end
    return ans;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random backpressure and in-order checking
  // ---------------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk);
      if (!steady_flow && $urandom_range(0, 5) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    wuf_res_t seen;
    wuf_res_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      seen.same_set     = out_if.same_set;
      seen.root_p       = out_if.root_p;
      seen.root_q       = out_if.root_q;
      seen.out_of_range = out_if.out_of_range;
      if (predicted_answers.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("[%0t] result word with nothing pending: same=%0b rp=%0d rq=%0d oor=%0b",
                   $realtime, seen.same_set, seen.root_p, seen.root_q,
                   seen.out_of_range);
      end else begin
        want = predicted_answers.pop_front();
        if (seen.same_set !== want.same_set || seen.root_p !== want.root_p ||
            seen.root_q !== want.root_q || seen.out_of_range !== want.out_of_range) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("[%0t] mismatch: exp %0b/%0d/%0d/%0b got %0b/%0d/%0d/%0b",
                     $realtime,
                     want.same_set, want.root_p, want.root_q, want.out_of_range,
                     seen.same_set, seen.root_p, seen.root_q, seen.out_of_range);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  // Called at a rising edge. Valid stays high after acceptance so that
  // back-to-back words need no extra edge; drain_requests lowers it.
  task automatic send_request(input wuf_req_t req);
    if (!steady_flow && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_if.valid  <= 1'b1;
    in_if.kind   <= req.kind;
    in_if.site_p <= req.site_p;
    in_if.site_q <= req.site_q;
    do @(posedge clk); while (!(in_if.valid && in_if.ready));
    predicted_answers.push_back(union_find_step(req));
  endtask

  task automatic send_words(input logic [1:0] kind, input int p, input int q);
    wuf_req_t req;
    req.kind   = kind;
    req.site_p = SITE_W'(p);
    req.site_q = SITE_W'(q);
    send_request(req);
  endtask

  task automatic drain_requests();
    in_if.valid <= 1'b0;
    while (predicted_answers.size() != 0) @(posedge clk);
  endtask

  // register writes only with the core idle: all results back and any
  // clearing sweep finished
  task automatic write_site_count(input logic [CFG_W-1:0] value);
    drain_requests();
    repeat (SWEEP_SETTLE) @(posedge clk);
    cfg_if.valid        <= 1'b1;
    cfg_if.sites_in_use <= value;
    do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
    cfg_if.valid      <= 1'b0;
    shadow_site_count  = value;
  endtask

  function automatic logic [SITE_W-1:0] pick_site(input int unsigned span);
    // mostly inside the working window, now and then anywhere in 10 bits
    if ($urandom_range(0, 9) == 0)
      return SITE_W'($urandom);
    return SITE_W'($urandom_range(0, span - 1));
  endfunction

  task automatic run_random_batch(input int unsigned span, input int count);
    wuf_req_t    req;
    int unsigned roll;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 46)      req.kind = KIND_MERGE;
      else if (roll < 92) req.kind = KIND_QUERY;
      else if (roll < 97) req.kind = KIND_SPARE;
      else                req.kind = KIND_REINIT;
      req.site_p = pick_site(span);
      req.site_q = pick_site(span);
      send_request(req);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Extremes, tie and weighted merges, joined merge, spare code.
  task automatic test_merge_rules();
    send_words(KIND_QUERY, 0, 0);
    send_words(KIND_QUERY, 1023, 0);
    send_words(KIND_MERGE, 0, 1);       // tie: 1 goes under 0
    send_words(KIND_MERGE, 2, 3);
    send_words(KIND_MERGE, 3, 1);       // tie of size 2: root 0 under root 2
    send_words(KIND_MERGE, 4, 1);       // singleton under the size-4 tree
    send_words(KIND_MERGE, 1, 3);       // already joined, no change
    send_words(KIND_QUERY, 0, 4);
    send_words(KIND_MERGE, 1023, 1022);
    send_words(KIND_SPARE, 1023, 0);
    send_words(KIND_MERGE, 5, 1023);    // p root is smaller, goes under q root
  endtask

  // Range checks across register values, including zero and above the depth.
  task automatic test_site_range();
    write_site_count(CFG_W'(1000));
    send_words(KIND_QUERY, 1000, 0);
    send_words(KIND_MERGE, 0, 1023);
    send_words(KIND_MERGE, 999, 998);
    send_words(KIND_QUERY, 999, 998);
    write_site_count(CFG_W'(0));        // every site out of range
    send_words(KIND_QUERY, 0, 0);
    write_site_count(CFG_W'(1));
    send_words(KIND_QUERY, 0, 0);
    send_words(KIND_MERGE, 0, 1);
    write_site_count(CFG_W'(2047));     // clamps to the table depth
    send_words(KIND_QUERY, 1023, 1022);
    send_words(KIND_MERGE, 1023, 0);
  endtask

  // Reinit wipes both tables whatever sites it carries.
  task automatic test_reinit();
    send_words(KIND_REINIT, 1023, 1023);
    send_words(KIND_QUERY, 0, 1);
    send_words(KIND_QUERY, 1023, 1022);
  endtask

  task automatic test_random_full_range();
    write_site_count(CFG_W'(1024));
    run_random_batch(1024, 150);
  endtask

  // narrow window so merges pile up into tall trees
  task automatic test_random_deep_trees();
    write_site_count(CFG_W'(24));
    run_random_batch(24, 150);
  endtask

  task automatic test_random_clamped_register();
    write_site_count(CFG_W'(2047));
    run_random_batch(64, 150);
  endtask

  task automatic test_random_single_site();
    write_site_count(CFG_W'(1));
    run_random_batch(1, 40);
  endtask

  task automatic test_random_midsize();
    int unsigned count;
    count = $urandom_range(2, 1024);
    write_site_count(CFG_W'(count));
    run_random_batch((count > 128) ? 128 : count, 160);
    write_site_count(CFG_W'(512));
    run_random_batch(256, 150);
  endtask

  task automatic test_random_steady();
    write_site_count(CFG_W'(1024));
    steady_flow = 1'b1;
    run_random_batch(200, 150);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n               = 1'b0;
    in_if.valid         = 1'b0;
    in_if.kind          = KIND_QUERY;
    in_if.site_p        = '0;
    in_if.site_q        = '0;
    out_if.ready        = 1'b1;
    cfg_if.valid        = 1'b0;
    cfg_if.sites_in_use = CFG_RESET;
    mismatch_count      = 0;
    steady_flow         = 1'b0;
    shadow_site_count   = CFG_RESET;
    clear_shadow_tables();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // the core holds off requests through its clearing sweep by itself
    test_merge_rules();
    test_site_range();
    test_reinit();
    test_random_full_range();
    test_random_deep_trees();
    test_random_clamped_register();
    test_random_single_site();
    test_random_midsize();
    test_random_steady();

    drain_requests();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
